/* src/assert_macros.svh */
// Assertion macros shared by the compensation core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/bsc_pkg.sv */
// Shared types, constants and helpers of the barometric compensation core
package bsc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_AC1   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC2   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC3   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_AC4   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AC5   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AC6   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BPAIR = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MPAIR = 3'd7;

  localparam logic [15:0] RstAc1   = 16'd408;
  localparam logic [15:0] RstAc2   = 16'hFFB8;
  localparam logic [15:0] RstAc3   = 16'hC7D1;
  localparam logic [15:0] RstAc4   = 16'd32741;
  localparam logic [15:0] RstAc5   = 16'd32757;
  localparam logic [15:0] RstAc6   = 16'd23153;
  localparam logic [31:0] RstBPair = 32'd405667844;
  localparam logic [31:0] RstMPair = 32'd3724086068;

  localparam logic [31:0] B6Offset   = 32'd4000;
  localparam logic [31:0] B7Scale    = 32'd50000;
  localparam logic [31:0] PCoefA     = 32'd3038;
  localparam logic [31:0] PCoefB     = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PCoefC     = 32'd3791;
  localparam logic [31:0] X3Offset   = 32'd32768;

  localparam logic REQ_TEMP  = 1'b0;
  localparam logic REQ_PRESS = 1'b1;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

/* src/bsc_mul.sv */
// Shared signed multiplier with registered product
module bsc_mul
  import bsc_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* src/bsc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle
`include "assert_macros.svh"
module bsc_div
  import bsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dq_q, dq_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] quot_q, quot_d;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    trial  = {rem_q, dq_q[31]};
    diff   = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = '0;
      dq_d   = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        dq_d  = {dq_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        dq_d  = {dq_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quot_d = dq_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  `BSC_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, req_i.start, busy_q)
  `BSC_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_q, !busy_q)

endmodule

/* src/barometric_sensor_compensation_core.sv */
// Barometric sensor compensation core: one item at a time through a shared
// multiplier and a bit-serial divider. The time from acceptance to result
// valid of a temperature item and of a pressure item is set by the divider
// plus the chain of multiplies on the one multiplier. The block stalls its
// input while an item is in work. Config writes are always ready and must
// only be made while the core is idle.
`include "assert_macros.svh"
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [23:0]         raw_sample_i,
  input  logic [1:0]          oversampling_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                result_kind_o,
  output logic signed [31:0]  result_value_o,
  output logic                divide_error_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_T2   = 5'd3;
  localparam logic [4:0] S_P0   = 5'd4;
  localparam logic [4:0] S_P1   = 5'd5;
  localparam logic [4:0] S_P2   = 5'd6;
  localparam logic [4:0] S_P3   = 5'd7;
  localparam logic [4:0] S_P4   = 5'd8;
  localparam logic [4:0] S_P5   = 5'd9;
  localparam logic [4:0] S_P6   = 5'd10;
  localparam logic [4:0] S_P7   = 5'd11;
  localparam logic [4:0] S_P8   = 5'd12;
  localparam logic [4:0] S_P9   = 5'd13;
  localparam logic [4:0] S_P10  = 5'd14;
  localparam logic [4:0] S_P11  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
  logic [31:0] bpair_q, mpair_q;

  logic [4:0]         state_q, state_d;
  logic               kind_q, kind_d;
  logic [23:0]        raw_q, raw_d;
  logic [1:0]         oss_q, oss_d;
  logic signed [31:0] tt_q, tt_d;
  logic [31:0]        up_q, up_d;
  logic signed [31:0] b6_q, b6_d;
  logic signed [31:0] sq_q, sq_d;
  logic signed [31:0] x1_q, x1_d;
  logic signed [31:0] b3_q, b3_d;
  logic [31:0]        b4_q, b4_d;
  logic               b7hi_q, b7hi_d;
  logic               qneg_q, qneg_d;
  logic signed [31:0] p_q, p_d;
  logic signed [31:0] res_q, res_d;
  logic               err_q, err_d;
  logic               ovld_q, ovld_d;
  logic               okind_q, okind_d;
  logic signed [31:0] oval_q, oval_d;
  logic               oerr_q, oerr_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] p32;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic signed [31:0] tdiv, tnum, qs, b5, x3, x2, pnow, tsh;
  logic [31:0]        b7;
  logic [3:0]         upsh;

  bsc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  bsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign p32 = prod[31:0];

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    raw_d   = raw_q;
    oss_d   = oss_q;
    tt_d    = tt_q;
    up_d    = up_q;
    b6_d    = b6_q;
    sq_d    = sq_q;
    x1_d    = x1_q;
    b3_d    = b3_q;
    b4_d    = b4_q;
    b7hi_d  = b7hi_q;
    qneg_d  = qneg_q;
    p_d     = p_q;
    res_d   = res_q;
    err_d   = err_q;
    ovld_d  = ovld_q;
    okind_d = okind_q;
    oval_d  = oval_q;
    oerr_d  = oerr_q;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    tdiv    = '0;
    tnum    = '0;
    qs      = '0;
    b5      = '0;
    x3      = '0;
    x2      = '0;
    pnow    = '0;
    tsh     = '0;
    b7      = '0;
    upsh    = 4'd8 - {2'b00, oss_q};

    if (ovld_q && !out_stall_i) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = req_type_i;
          raw_d   = raw_sample_i;
          oss_d   = oversampling_i;
          state_d = (req_type_i == REQ_PRESS) ? S_P0 : S_T0;
        end
      end
      S_T0: begin
        mul_a   = $signed({17'd0, raw_q[15:0]}) - $signed({17'd0, ac6_q});
        mul_b   = $signed({17'd0, ac5_q});
        state_d = S_T1;
      end
      S_T1: begin
        x1_d = prod[46:15];
        tdiv = prod[46:15] + sx16(mpair_q[15:0]);
        tnum = {{5{mpair_q[31]}}, mpair_q[31:16], 11'd0};
        if (tdiv == 32'sd0) begin
          res_d   = '0;
          err_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          qneg_d           = tnum[31] ^ tdiv[31];
          div_req.start    = 1'b1;
          div_req.dividend = tnum[31] ? -tnum : tnum;
          div_req.divisor  = tdiv[31] ? -tdiv : tdiv;
          state_d          = S_T2;
        end
      end
      S_T2: begin
        if (div_rsp.done) begin
          qs      = qneg_q ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
          b5      = x1_q + qs;
          tt_d    = b5;
          res_d   = (b5 + 32'sd8) >>> 4;
          err_d   = 1'b0;
          state_d = S_OUT;
        end
      end
      S_P0: begin
        up_d    = {8'd0, raw_q >> upsh};
        b6_d    = tt_q - $signed(B6Offset);
        mul_a   = {b6_d[31], b6_d};
        mul_b   = {b6_d[31], b6_d};
        state_d = S_P1;
      end
      S_P1: begin
        sq_d    = p32 >>> 12;
        mul_a   = {sq_d[31], sq_d};
        mul_b   = {{17{bpair_q[15]}}, bpair_q[15:0]};
        state_d = S_P2;
      end
      S_P2: begin
        x1_d    = p32 >>> 11;
        mul_a   = {{17{ac2_q[15]}}, ac2_q};
        mul_b   = {b6_q[31], b6_q};
        state_d = S_P3;
      end
      S_P3: begin
        x3      = x1_q + (p32 >>> 11);
        b3_d    = (((sx16(ac1_q) <<< 2) + x3) <<< oss_q) + 32'sd2;
        b3_d    = b3_d >>> 2;
        mul_a   = {{17{ac3_q[15]}}, ac3_q};
        mul_b   = {b6_q[31], b6_q};
        state_d = S_P4;
      end
      S_P4: begin
        x1_d    = p32 >>> 13;
        mul_a   = {{17{bpair_q[31]}}, bpair_q[31:16]};
        mul_b   = {sq_q[31], sq_q};
        state_d = S_P5;
      end
      S_P5: begin
        x3      = (x1_q + (p32 >>> 16) + 32'sd2) >>> 2;
        x3      = x3 + $signed(X3Offset);
        mul_a   = {17'd0, ac4_q};
        mul_b   = {x3[31], x3};
        state_d = S_P6;
      end
      S_P6: begin
        b4_d    = prod[31:0] >> 15;
        mul_a   = {1'b0, up_q - b3_q};
        mul_b   = {1'b0, B7Scale >> oss_q};
        state_d = S_P7;
      end
      S_P7: begin
        b7 = prod[31:0];
        if (b4_q == 32'd0) begin
          res_d   = '0;
          err_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          b7hi_d           = b7[31];
          div_req.start    = 1'b1;
          div_req.dividend = b7[31] ? b7 : {b7[30:0], 1'b0};
          div_req.divisor  = b4_q;
          state_d          = S_P8;
        end
      end
      S_P8: begin
        pnow = b7hi_q ? {div_rsp.quot[30:0], 1'b0} : div_rsp.quot;
        tsh  = pnow >>> 8;
        mul_a = {tsh[31], tsh};
        mul_b = {tsh[31], tsh};
        if (div_rsp.done) begin
          p_d     = pnow;
          state_d = S_P9;
        end
      end
      S_P9: begin
        mul_a   = {p32[31], p32};
        mul_b   = {1'b0, PCoefA};
        state_d = S_P10;
      end
      S_P10: begin
        x1_d    = p32 >>> 16;
        mul_a   = {p_q[31], p_q};
        mul_b   = {PCoefB[31], PCoefB};
        state_d = S_P11;
      end
      S_P11: begin
        x2      = p32 >>> 16;
        res_d   = p_q + ((x1_q + x2 + $signed(PCoefC)) >>> 4);
        err_d   = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          okind_d = kind_q;
          oval_d  = res_q;
          oerr_d  = err_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      tt_q    <= '0;
      ac1_q   <= RstAc1;
      ac2_q   <= RstAc2;
      ac3_q   <= RstAc3;
      ac4_q   <= RstAc4;
      ac5_q   <= RstAc5;
      ac6_q   <= RstAc6;
      bpair_q <= RstBPair;
      mpair_q <= RstMPair;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      tt_q    <= tt_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_AC1:   ac1_q   <= cfg_data_i[15:0];
          REG_AC2:   ac2_q   <= cfg_data_i[15:0];
          REG_AC3:   ac3_q   <= cfg_data_i[15:0];
          REG_AC4:   ac4_q   <= cfg_data_i[15:0];
          REG_AC5:   ac5_q   <= cfg_data_i[15:0];
          REG_AC6:   ac6_q   <= cfg_data_i[15:0];
          REG_BPAIR: bpair_q <= cfg_data_i;
          REG_MPAIR: mpair_q <= cfg_data_i;
          default:   ac1_q   <= ac1_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    raw_q   <= raw_d;
    oss_q   <= oss_d;
    up_q    <= up_d;
    b6_q    <= b6_d;
    sq_q    <= sq_d;
    x1_q    <= x1_d;
    b3_q    <= b3_d;
    b4_q    <= b4_d;
    b7hi_q  <= b7hi_d;
    qneg_q  <= qneg_d;
    p_q     <= p_d;
    res_q   <= res_d;
    err_q   <= err_d;
    okind_q <= okind_d;
    oval_q  <= oval_d;
    oerr_q  <= oerr_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = ovld_q;
  assign result_kind_o  = okind_q;
  assign result_value_o = oval_q;
  assign divide_error_o = oerr_q;

  `BSC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o,
                   state_q != S_IDLE)
  `BSC_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && divide_error_o,
                  result_value_o == 32'sd0)
  `BSC_ASSERT_NOW(a_out_load, clk_i, rst_ni, state_q == S_OUT && ovld_q && out_stall_i,
                  state_d == S_OUT)

endmodule
